/* design/lts_pkg.sv */
// Shared types and constants for the line transmit slot queue.
// No dependencies; every other design file refers to this package by scoped names.
`default_nettype none
package lts_pkg;

  // Ring geometry. Both sizes must be powers of two: slot addressing
  // concatenates the slot index and the byte position.
  localparam int SLOTS     = 8;
  localparam int SLOT_SIZE = 64;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int POS_W     = $clog2(SLOT_SIZE);
  localparam int LEN_W     = POS_W + 1;
  localparam int ADDR_W    = IDX_W + POS_W;
  localparam int FREE_W    = 8;

  localparam logic [7:0] NEWLINE = 8'h0A;

  typedef enum logic [1:0] {
    FN_CHAR   = 2'd0,
    FN_COMMIT = 2'd1,
    FN_SEND   = 2'd2,
    FN_XERR   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Slot store access issued by the control for one item.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  // Registered result fields, except the byte, which comes from the store.
  typedef struct packed {
    logic              vld;
    logic              byte_vld;
    logic              last;
    status_t           status;
    logic [FREE_W-1:0] free_slots;
    logic              busy;
  } res_t;

endpackage
`default_nettype wire

/* design/lts_slot_ram.sv */
// Slot byte store: one write port, one read port with registered read data.
// Depends on lts_pkg for the address width and depth.
`default_nettype none
module lts_slot_ram (
  input  wire logic                      clk,
  input  wire lts_pkg::mem_req_t         req,
  output logic [7:0]                     rd_data_r
);

  logic [7:0] mem [lts_pkg::SLOTS*lts_pkg::SLOT_SIZE];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

endmodule
`default_nettype wire

/* design/lts_ctrl.sv */
// Queue control: head/tail pointers, line fill state, slot lengths, result register.
// Depends on lts_pkg; drives the slot store lts_slot_ram.
`default_nettype none
module lts_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,       // pipeline moves this cycle
  input  wire logic             item_vld,  // input register holds an item
  input  wire lts_pkg::func_t   func,
  input  wire logic [7:0]       ch,
  output lts_pkg::mem_req_t     mreq,
  output lts_pkg::res_t         res_r
);

  localparam int IW = lts_pkg::IDX_W;
  localparam int PW = lts_pkg::POS_W;
  localparam int LW = lts_pkg::LEN_W;

  logic [IW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [PW-1:0] wcnt_r, wcnt_nxt, rpos_r, rpos_nxt;
  logic          zseen_r, zseen_nxt;
  logic          lastnl_r, lastnl_nxt;  // last kept character is a newline
  logic [LW-1:0] slot_len_r [lts_pkg::SLOTS];
  logic          len_we;
  logic [LW-1:0] len_wd;
  lts_pkg::res_t res_nxt;
  logic          go;
  logic [LW-1:0] rpos_inc;
  logic [IW-1:0] free_idx;  // free slot count, wraps at the ring size

  assign go       = adv & item_vld;
  assign rpos_inc = {1'b0, rpos_r} + LW'(1);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    wcnt_nxt   = wcnt_r;
    rpos_nxt   = rpos_r;
    zseen_nxt  = zseen_r;
    lastnl_nxt = lastnl_r;
    len_we     = 1'b0;
    len_wd     = {1'b0, wcnt_r};
    mreq       = '0;
    mreq.rd_addr = {tail_r, rpos_r};
    res_nxt    = '0;
    res_nxt.vld    = item_vld;
    res_nxt.status = lts_pkg::ST_OK;

    case (func)
      lts_pkg::FN_CHAR: begin
        if (!zseen_r) begin
          if (ch == 8'd0) begin
            zseen_nxt = 1'b1;
          end else if (wcnt_r != PW'(lts_pkg::SLOT_SIZE - 1)) begin
            mreq.wr_en   = go;
            mreq.wr_addr = {head_r, wcnt_r};
            mreq.wr_data = ch;
            wcnt_nxt     = wcnt_r + PW'(1);
            lastnl_nxt   = (ch == lts_pkg::NEWLINE);
          end
        end
      end
      lts_pkg::FN_COMMIT: begin
        if (head_r + IW'(1) == tail_r) begin
          res_nxt.status = lts_pkg::ST_FULL;
        end else begin
          len_we = go;
          if (wcnt_r == '0 || !lastnl_r) begin
            // Append the closing newline.
            mreq.wr_en   = go;
            mreq.wr_addr = {head_r, wcnt_r};
            mreq.wr_data = lts_pkg::NEWLINE;
            len_wd       = {1'b0, wcnt_r} + LW'(1);
          end
          head_nxt = head_r + IW'(1);
        end
        wcnt_nxt   = '0;
        zseen_nxt  = 1'b0;
        lastnl_nxt = 1'b0;
      end
      lts_pkg::FN_SEND: begin
        if (head_r == tail_r) begin
          res_nxt.status = lts_pkg::ST_EMPTY;
        end else begin
          mreq.rd_en       = go;
          res_nxt.byte_vld = 1'b1;
          if (rpos_inc >= slot_len_r[tail_r]) begin
            res_nxt.last = 1'b1;
            tail_nxt     = tail_r + IW'(1);
            rpos_nxt     = '0;
          end else begin
            rpos_nxt = rpos_inc[PW-1:0];
          end
        end
      end
      lts_pkg::FN_XERR: begin
        if (head_r == tail_r) begin
          res_nxt.status = lts_pkg::ST_EMPTY;
        end else begin
          tail_nxt = tail_r + IW'(1);
          rpos_nxt = '0;
        end
      end
      default: begin
        res_nxt.vld = item_vld;
      end
    endcase

    free_idx           = tail_nxt - head_nxt - IW'(1);
    res_nxt.free_slots = lts_pkg::FREE_W'(free_idx);
    res_nxt.busy       = (head_nxt != tail_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      wcnt_r   <= '0;
      rpos_r   <= '0;
      zseen_r  <= 1'b0;
      lastnl_r <= 1'b0;
      res_r    <= '0;
    end else if (adv) begin
      res_r <= res_nxt;
      if (item_vld) begin
        head_r   <= head_nxt;
        tail_r   <= tail_nxt;
        wcnt_r   <= wcnt_nxt;
        rpos_r   <= rpos_nxt;
        zseen_r  <= zseen_nxt;
        lastnl_r <= lastnl_nxt;
      end
    end
  end

  // Slot lengths are only read for committed slots, so they need no reset.
  always_ff @(posedge clk) begin
    if (len_we) begin
      slot_len_r[head_r] <= len_wd;
    end
  end

endmodule
`default_nettype wire

/* design/line_transmit_slot_queue.sv */
// Top level of the line transmit slot queue: input register, control, slot store.
// Depends on lts_pkg, lts_ctrl and lts_slot_ram.
//
//   channel | dir | tdata                      | tuser    | tlast
//   in_     | in  | ch[7:0]                    | func[1:0]| -
//   out_    | out | valid,byte,status,free,busy| -        | out_last
//
// Every item gives exactly one result item: it passes the input register,
// then the control logic into the result register (a send's byte is read
// from the slot store as the result is registered).
// Sustained rate is one item per clock while the output is not stalled.
// rst_n is synchronous, active low; it clears pointers and line state.
// A stalled output holds the whole pipeline; the input register still takes
// an item while it is empty.
`default_nettype none
module line_transmit_slot_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] ch
  input  wire logic [1:0]  in_tuser,   // [1:0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [0] out_valid, [8:1] out_byte, [10:9] status,
                                       // [18:11] free_slots, [19] busy_res, rest zero
  output logic             out_tlast   // out_last
);

  logic              in_vld_r, in_vld_nxt;
  lts_pkg::func_t    func_r;
  logic [7:0]        ch_r;
  logic              adv;
  lts_pkg::mem_req_t mreq;
  lts_pkg::res_t     res_r;
  logic [7:0]        rd_data_r;
  logic [7:0]        out_byte;

  // Pipeline advances whenever the result register is free or being taken.
  assign adv       = !res_r.vld || out_tready;
  assign in_tready = !in_vld_r || adv;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_tvalid && in_tready) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      func_r <= lts_pkg::func_t'(in_tuser);
      ch_r   <= in_tdata;
    end
  end

  lts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .item_vld (in_vld_r),
    .func     (func_r),
    .ch       (ch_r),
    .mreq     (mreq),
    .res_r    (res_r)
  );

  lts_slot_ram u_ram (
    .clk       (clk),
    .req       (mreq),
    .rd_data_r (rd_data_r)
  );

  // Store read data is only meaningful for a send that produced a byte.
  assign out_byte   = res_r.byte_vld ? rd_data_r : 8'd0;
  assign out_tvalid = res_r.vld;
  assign out_tlast  = res_r.last;
  assign out_tdata  = {4'd0, res_r.busy, res_r.free_slots, res_r.status,
                       out_byte, res_r.byte_vld};

`ifndef SYNTH
  // Busy exactly when the ring is not completely free.
  a_busy_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res_r.busy ==
      (res_r.free_slots != lts_pkg::FREE_W'(lts_pkg::SLOTS - 1))))
    else $error("busy flag disagrees with free slot count");

  // A last marker only comes with a sent byte.
  a_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> res_r.byte_vld)
    else $error("last marker without a byte");

  // A sent byte always carries an ok status.
  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_r.byte_vld) |-> (res_r.status == lts_pkg::ST_OK))
    else $error("byte sent with error status");
`endif

endmodule
`default_nettype wire
